>>> rtl/sliding_median_filter_unit_assert.svh
// Assertion macros for the running median filter
`ifndef SLIDING_MEDIAN_FILTER_UNIT_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent
`define SMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/smf_pkg.sv
package smf_pkg;

	// Default sizing
	localparam int MAX_RADIUS_DEF  = 4;
	localparam int SAMPLE_BITS_DEF = 16;

	// Radius register
	localparam int              RADIUS_BITS  = 3;
	localparam logic [2:0]      RADIUS_RESET = 3'd1;

	// Sequencer states
	typedef enum logic [0:0] {
		ST_STREAM,
		ST_FLUSH
	} smf_state_t;

endpackage

>>> rtl/smf_if.sv
// Sample input channel
interface smf_in_if #(parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          end_of_signal;

	modport source(output valid, sample, end_of_signal, input ready);
	modport sink(input valid, sample, end_of_signal, output ready);
endinterface

// Filtered result channel
interface smf_out_if #(parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered;
	logic                          final_result;

	modport source(output valid, filtered, final_result, input ready);
	modport sink(input valid, filtered, final_result, output ready);
endinterface

// Radius write channel
interface smf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [smf_pkg::RADIUS_BITS-1:0]    radius;

	modport source(output valid, radius, input ready);
	modport sink(input valid, radius, output ready);
endinterface

>>> rtl/smf_cell.sv
// One window cell: holds a sample, passes it on at each shift and ranks it
// against the rest of the active window (ties broken by age).
module smf_cell #(
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
	parameter int DEPTH       = 2 * smf_pkg::MAX_RADIUS_DEF + 1,
	parameter int IDX         = 0,
	parameter int RANK_W      = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               shift_en,
	input  logic signed [SAMPLE_BITS-1:0]      din,
	input  logic [DEPTH-1:0][SAMPLE_BITS-1:0]  taps,
	input  logic [DEPTH-1:0]                   in_win,
	output logic signed [SAMPLE_BITS-1:0]      dout,
	output logic [RANK_W-1:0]                  rank
);
	import smf_pkg::*;

	logic signed [SAMPLE_BITS-1:0] sample_q;

	// Shift from the younger neighbour
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= din;
		end
	end

	assign dout = sample_q;

	// Count window members that sort ahead of this one
	always_comb begin
		rank = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if (in_win[j] && (j != IDX)) begin
				if (($signed(taps[j]) < sample_q) ||
				    (($signed(taps[j]) == sample_q) && (j < IDX))) begin
					rank = rank + RANK_W'(1);
				end
			end
		end
	end

endmodule

>>> rtl/smf_window.sv
// Chain of window cells with median pick and a single tap read
module smf_window #(
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_RADIUS  = smf_pkg::MAX_RADIUS_DEF
) (
	input  logic                                         clk,
	input  logic                                         shift_en,
	input  logic signed [SAMPLE_BITS-1:0]                din,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]              r,
	input  logic [$clog2(2*MAX_RADIUS+1)-1:0]            tap_idx,
	output logic signed [SAMPLE_BITS-1:0]                median,
	output logic signed [SAMPLE_BITS-1:0]                tap
);
	import smf_pkg::*;

	localparam int DEPTH = 2 * MAX_RADIUS + 1;
	localparam int IW    = $clog2(DEPTH);
	localparam int WW    = IW + 1;

	logic [DEPTH-1:0][SAMPLE_BITS-1:0] taps;
	logic [DEPTH-1:0][IW-1:0]          ranks;
	logic [DEPTH-1:0]                  in_win;
	logic [WW-1:0]                     two_r;
	logic [SAMPLE_BITS-1:0]            med_or;

	assign two_r = WW'({r, 1'b0});

	// Cell chain, newest sample at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] cell_din;
		logic signed [SAMPLE_BITS-1:0] cell_dout;

		if (i == 0) begin : g_head
			assign cell_din = din;
		end else begin : g_link
			assign cell_din = $signed(taps[i-1]);
		end

		assign in_win[i] = (WW'(i) <= two_r);
		assign taps[i]   = cell_dout;

		smf_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.DEPTH       (DEPTH),
			.IDX         (i),
			.RANK_W      (IW)
		) u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.din      (cell_din),
			.taps     (taps),
			.in_win   (in_win),
			.dout     (cell_dout),
			.rank     (ranks[i])
		);
	end

	// The cell ranked at r is the median
	always_comb begin
		med_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (in_win[i] && (ranks[i] == IW'(r))) begin
				med_or = med_or | taps[i];
			end
		end
	end

	assign median = $signed(med_or);
	assign tap    = $signed(taps[tap_idx]);

endmodule

>>> rtl/sliding_median_filter_unit.sv
// Running median filter over a signed sample stream.
// Channels: stream (sample, end_of_signal) in, result (filtered, final_result)
// out, cfg writes the radius (clamped to MAX_RADIUS, takes effect on the
// next sample). cfg is always ready; write it only while the block is idle.
// Each result lags the input by radius samples; the first radius samples of
// a signal produce no result, the end_of_signal sample produces up to
// radius+1 results, the last of them marked by final_result.
// Datapath: a result passes from its sample transaction through the stage-1
// pending register into the output register. The cell chain ranks the whole
// window combinationally, so one sample per clock is taken while results
// drain and the output is not held. After an end_of_signal sample input is
// held off for the flush, each flushed position bound to the output register.
// Stalls: a held result blocks the next pending one, which in turn drops
// stream.ready, so nothing is lost or reordered.
// Reset: radius returns to 1, the sample count to zero and all queued
// results are dropped; no clearing pass is needed.
module sliding_median_filter_unit #(
	parameter int MAX_RADIUS  = smf_pkg::MAX_RADIUS_DEF,
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	smf_cfg_if.sink   cfg,
	smf_in_if.sink    stream,
	smf_out_if.source result
);
	import smf_pkg::*;

	localparam int DEPTH = 2 * MAX_RADIUS + 1;
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int IW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = CNT_W + 1;

	logic [RADIUS_BITS-1:0]        radius_q;
	logic [RW-1:0]                 r_now;
	logic [CNT_W-1:0]              seen_q;
	logic                          accept;

	// Pending item (stage 1)
	logic                          pend_q;
	logic                          last_s1;
	logic                          emit_s1;
	logic                          mid_s1;
	logic [RW-1:0]                 r_s1;
	logic [CNT_W-1:0]              n_s1;

	smf_state_t                    state_q;
	smf_state_t                    state_d;
	logic [IW-1:0]                 kf_q;
	logic [IW-1:0]                 kf_start;
	logic                          flush_start;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic                          final_q;
	logic                          out_free;
	logic                          pend_done;
	logic                          flush_step;
	logic                          stream_ready;
	logic                          out_load;
	logic signed [SAMPLE_BITS-1:0] out_value;
	logic                          out_final;

	logic [IW-1:0]                 tap_idx;
	logic signed [SAMPLE_BITS-1:0] median;
	logic signed [SAMPLE_BITS-1:0] tap;

	// Radius register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			radius_q <= cfg.radius;
		end
	end

	always_comb begin
		if (int'(radius_q) > MAX_RADIUS) begin
			r_now = RW'(MAX_RADIUS);
		end else begin
			r_now = RW'(radius_q);
		end
	end

	assign accept = stream.valid && stream_ready;

	// Saturating sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			if (stream.end_of_signal) begin
				seen_q <= '0;
			end else if (seen_q < CNT_W'(DEPTH)) begin
				seen_q <= seen_q + CNT_W'(1);
			end
		end
	end

	// Stage 1 decode of the accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= stream.end_of_signal;
			emit_s1 <= CMP_W'(seen_q) >= CMP_W'(r_now);
			mid_s1  <= CMP_W'(seen_q) >= CMP_W'({r_now, 1'b0});
			r_s1    <= r_now;
			n_s1    <= seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (pend_done) begin
			pend_q <= 1'b0;
		end
	end

	// Handshake helpers
	assign out_free    = !out_valid_q || result.ready;
	assign pend_done   = (state_q == ST_STREAM) && pend_q && (!emit_s1 || out_free);
	assign flush_step  = (state_q == ST_FLUSH) && out_free;
	assign flush_start = last_s1 && !(emit_s1 && (r_s1 == '0));
	assign kf_start    = emit_s1 ? IW'(RW'(r_s1 - RW'(1))) : IW'(n_s1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_STREAM: begin
				if (pend_done && flush_start) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_step && (kf_q == '0)) begin
					state_d = ST_STREAM;
				end
			end
			default: begin
				state_d = ST_STREAM;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		stream_ready = 1'b0;
		out_load     = 1'b0;
		out_value    = tap;
		out_final    = 1'b0;
		tap_idx      = IW'(r_s1);
		case (state_q)
			ST_STREAM: begin
				stream_ready = !pend_q || (pend_done && !last_s1);
				out_load     = pend_q && emit_s1 && out_free;
				out_value    = mid_s1 ? median : tap;
				out_final    = last_s1 && (r_s1 == '0);
			end
			ST_FLUSH: begin
				tap_idx   = kf_q;
				out_load  = out_free;
				out_value = tap;
				out_final = (kf_q == '0);
			end
			default: begin
				stream_ready = 1'b0;
			end
		endcase
	end

	assign stream.ready = stream_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_STREAM;
			kf_q    <= '0;
		end else begin
			state_q <= state_d;
			if (pend_done) begin
				kf_q <= kf_start;
			end else if (flush_step && (kf_q != '0)) begin
				kf_q <= kf_q - IW'(1);
			end
		end
	end

	// Window cell chain
	smf_window #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_RADIUS  (MAX_RADIUS)
	) u_window (
		.clk      (clk),
		.shift_en (accept),
		.din      (stream.sample),
		.r        (r_s1),
		.tap_idx  (tap_idx),
		.median   (median),
		.tap      (tap)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= out_value;
			final_q    <= out_final;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.filtered     = filtered_q;
	assign result.final_result = final_q;

	// Checks
	`include "sliding_median_filter_unit_assert.svh"

	`SMF_ASSERT_NOW(a_no_accept_in_flush, state_q == ST_FLUSH, !stream.ready, "input taken during flush")
	`SMF_ASSERT_NOW(a_hold_after_last, pend_q && last_s1, !stream.ready, "input taken behind last sample")
	`SMF_ASSERT_NEXT(a_flush_steps, flush_step && (kf_q != '0), (state_q == ST_FLUSH) && (kf_q == $past(kf_q) - IW'(1)), "flush index did not step")
	`SMF_ASSERT_NOW(a_seen_bound, 1'b1, seen_q <= CNT_W'(DEPTH), "sample count past window depth")

endmodule
